// ----- rtl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ENTRY_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // Signed search bounds: must hold -1 up to TABLE_DEPTH and the sum lo + hi
  localparam int BND_W       = ADDR_W + 2;

  // Fixed field widths
  localparam int KEY_W       = 32;
  localparam int INDEX_W     = 10;
  localparam int SIZE_W      = 11;
  localparam int CMP_W       = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

  // Opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Input item
  typedef struct packed {
    logic                      opcode;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0]   entry_value;
    logic signed [KEY_W-1:0]   search_key;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                      found;
    logic [INDEX_W-1:0]        match_index;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic write;        // store the input entry
    logic load_bounds;  // latch key, set lo/hi for a new search
    logic issue;        // read the midpoint entry
    logic update;       // move a bound past the probe
    logic hit;          // record a match at the probe
    logic miss;         // record not found
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic live;         // hi >= lo
    logic lt;           // probed entry below key
    logic gt;           // probed entry above key
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/stbs_ram.sv -----
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stbs_dp.sv -----
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath: size register, table memory, search bounds, compare and result.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [stbs_pkg::SIZE_W-1:0]  cfg_wdata,
  input  wire stbs_pkg::in_item_t           in_data,
  input  wire stbs_pkg::dp_cmd_t            cmd,
  output      stbs_pkg::dp_sts_t            sts,
  output      stbs_pkg::out_item_t          res
);

  logic [stbs_pkg::SIZE_W-1:0]          table_size_r;
  logic signed [stbs_pkg::BND_W-1:0]    lo_r;
  logic signed [stbs_pkg::BND_W-1:0]    hi_r;
  logic signed [stbs_pkg::BND_W-1:0]    lo_nxt;
  logic signed [stbs_pkg::BND_W-1:0]    hi_nxt;
  logic signed [stbs_pkg::BND_W-1:0]    bnd_sum;
  logic [stbs_pkg::ADDR_W-1:0]          mid;
  logic [stbs_pkg::ADDR_W-1:0]          mid_r;
  logic signed [stbs_pkg::KEY_W-1:0]    key_r;
  logic [31:0]                          size_w;
  logic [31:0]                          size_sat;
  logic                                 slot_ok;
  logic [stbs_pkg::ADDR_W-1:0]          waddr;
  logic signed [stbs_pkg::CMP_W-1:0]    val_ext;
  logic [stbs_pkg::ENTRY_WIDTH-1:0]     rdata;
  logic signed [stbs_pkg::CMP_W-1:0]    ent_ext;
  logic signed [stbs_pkg::CMP_W-1:0]    key_ext;
  stbs_pkg::out_item_t                  res_r;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // Load path: drop slots beyond the table, wrap the value to entry width
  assign slot_ok = ({22'd0, in_data.entry_index} < 32'(stbs_pkg::TABLE_DEPTH));
  assign waddr   = stbs_pkg::ADDR_W'(in_data.entry_index);
  assign val_ext = stbs_pkg::CMP_W'(in_data.entry_value);

  // Floor midpoint; both bounds are non-negative while the search is live
  assign bnd_sum = lo_r + hi_r;
  assign mid     = bnd_sum[stbs_pkg::ADDR_W:1];

  stbs_ram #(
    .WIDTH (stbs_pkg::ENTRY_WIDTH),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write && slot_ok),
    .waddr (waddr),
    .wdata (val_ext[stbs_pkg::ENTRY_WIDTH-1:0]),
    .re    (cmd.issue),
    .raddr (mid),
    .rdata (rdata)
  );

  // Compare the probed entry against the key at full width
  assign ent_ext = stbs_pkg::CMP_W'($signed(rdata));
  assign key_ext = stbs_pkg::CMP_W'(key_r);

  assign sts.live = (hi_r >= lo_r);
  assign sts.lt   = (ent_ext < key_ext);
  assign sts.gt   = (ent_ext > key_ext);

  // Saturate the covered size to the table depth
  assign size_w   = 32'(table_size_r);
  assign size_sat = (size_w > 32'(stbs_pkg::TABLE_DEPTH)) ?
                    32'(stbs_pkg::TABLE_DEPTH) : size_w;

  // Next bounds
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load_bounds) begin
      lo_nxt = '0;
      hi_nxt = stbs_pkg::BND_W'(size_sat) - stbs_pkg::BND_W'(1);
    end else if (cmd.update) begin
      if (sts.lt) begin
        lo_nxt = stbs_pkg::BND_W'(mid_r) + stbs_pkg::BND_W'(1);
      end else begin
        hi_nxt = stbs_pkg::BND_W'(mid_r) - stbs_pkg::BND_W'(1);
      end
    end
  end

  // Hold bounds, key, probe slot and result
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.load_bounds) begin
      key_r <= in_data.search_key;
    end
    if (cmd.issue) begin
      mid_r <= mid;
    end
    if (cmd.hit) begin
      res_r.found       <= 1'b1;
      res_r.match_index <= stbs_pkg::INDEX_W'(mid_r);
    end else if (cmd.miss) begin
      res_r.found       <= 1'b0;
      res_r.match_index <= '0;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- rtl/stbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: accepts items and steps the search probe by probe.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 opcode,
  input  wire stbs_pkg::dp_sts_t    sts,
  output      stbs_pkg::dp_cmd_t    cmd,
  output      logic                 busy,
  output      logic                 out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   busy_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;

  assign accept = start && !busy_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == stbs_pkg::OP_SEARCH) begin
            cmd.load_bounds = 1'b1;
            state_nxt       = ST_PROBE;
            busy_nxt        = 1'b1;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts.live) begin
          cmd.issue = 1'b1;
          state_nxt = ST_CMP;
        end else begin
          cmd.miss      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          busy_nxt      = 1'b0;
        end
      end
      ST_CMP: begin
        if (sts.lt || sts.gt) begin
          cmd.update = 1'b1;
          state_nxt  = ST_PROBE;
        end else begin
          cmd.hit       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          busy_nxt      = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/sorted_table_binary_search_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Binary search over a loaded table of sorted signed entries.
// ----------------------------------------------------------------------------
// Load: written at the transfer, no result, busy stays low. Search: P
// probes (at most 11 for 1024 entries), each a table read, then a compare;
// the result strobe follows the last compare on a match, or the probe
// state that finds hi below lo on a miss. busy falls with the strobe, so
// searches run one at a time. The strobe lasts one cycle; no stall.
// Synchronous reset clears the controller and table_size, not the table.
`default_nettype none

module sorted_table_binary_search_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [stbs_pkg::SIZE_W-1:0]  cfg_wdata,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire stbs_pkg::in_item_t           in_data,
  output      logic                         out_valid,
  output      stbs_pkg::out_item_t          out_data
);

  stbs_pkg::dp_cmd_t cmd;
  stbs_pkg::dp_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_data.opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  stbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .res       (out_data)
  );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sorted table binary search unit. Loads sorted tables of
// many sizes, runs directed and random key searches, and checks every
// result strobe against a shadow copy of the table searched the same way.
// ----------------------------------------------------------------------------

module tb_top;
  import stbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int RANDOM_ITEMS   = 500;

  localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7FFF_FFFF;
  localparam longint                  ENTRY_MIN = -64'sd2147483648;
  localparam longint                  ENTRY_MAX = 64'sd2147483647;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic              start     = 1'b0;
  logic              busy;
  in_item_t          in_data   = '0;
  logic              out_valid;
  out_item_t         out_data;

  sorted_table_binary_search_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Shadow copy of the table and the size register
  logic signed [KEY_W-1:0] entry_shadow [TABLE_DEPTH];
  int unsigned             size_shadow = 0;
  out_item_t               pending_lookups [$];
  int unsigned             mismatch_count = 0;
  int unsigned             idle_pct = 0;
  int unsigned             watchdog_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Walk the shadow table with the same probe order as the block
  function automatic out_item_t lookup_key(input logic signed [KEY_W-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    int        span;
    out_item_t res;
    span = (size_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_shadow);
    lo   = 0;
    hi   = span - 1;
    res  = '0;
    while (hi >= lo) begin
      mid = (lo + hi) / 2;
      if (entry_shadow[mid] < key) begin
        lo = mid + 1;
      end else if (entry_shadow[mid] > key) begin
        hi = mid - 1;
      end else begin
        res.found       = 1'b1;
        res.match_index = mid[INDEX_W-1:0];
        break;
      end
    end
    return res;
  endfunction

  // Mostly keys that sit in the table or next to an entry, some far off
  function automatic logic signed [KEY_W-1:0] pick_key(input int unsigned span);
    int unsigned             r;
    logic signed [KEY_W-1:0] k;
    r = $urandom_range(99);
    if (span != 0 && r < 50) begin
      k = entry_shadow[$urandom_range(span - 1)];
    end else if (span != 0 && r < 65) begin
      k = entry_shadow[$urandom_range(span - 1)] + ($urandom_range(1) ? 1 : -1);
    end else if (r < 80) begin
      k = $urandom;
    end else if (r < 90) begin
      k = $urandom_range(1) ? KEY_MAX : KEY_MIN;
    end else begin
      k = int'($urandom_range(16)) - 8;
    end
    return k;
  endfunction

  // Drive one item, idle first at random, hold until the transfer
  task automatic send_item(input in_item_t item);
    in_item_t junk;
    while ($urandom_range(99) < idle_pct) begin
      junk.opcode      = $urandom_range(1);
      junk.entry_index = $urandom_range(TABLE_DEPTH - 1);
      junk.entry_value = $urandom;
      junk.search_key  = $urandom;
      start   <= 1'b0;
      in_data <= junk;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    // Update the shadow state in transfer order
    if (item.opcode == OP_LOAD) begin
      entry_shadow[item.entry_index] = item.entry_value;
    end else begin
      pending_lookups.push_back(lookup_key(item.search_key));
    end
  endtask

  task automatic load_entry(input int unsigned slot, input logic signed [KEY_W-1:0] value);
    in_item_t item;
    item.opcode      = OP_LOAD;
    item.entry_index = slot[INDEX_W-1:0];
    item.entry_value = value;
    item.search_key  = $urandom;
    send_item(item);
  endtask

  task automatic search_for(input logic signed [KEY_W-1:0] key);
    in_item_t item;
    item.opcode      = OP_SEARCH;
    item.entry_index = $urandom_range(TABLE_DEPTH - 1);
    item.entry_value = $urandom;
    item.search_key  = key;
    send_item(item);
  endtask

  // Fill slots 0..count-1 in ascending order; a zero step makes duplicates
  task automatic load_sorted(input int unsigned count, input longint first,
                             input int unsigned max_step);
    longint v;
    v = first;
    for (int unsigned i = 0; i < count; i++) begin
      load_entry(i, v[KEY_W-1:0]);
      v = v + longint'($urandom_range(0, max_step));
      if (v > ENTRY_MAX) v = ENTRY_MAX;
    end
  endtask

  // Drop start, drain all results, then let a trailing load finish
  task automatic settle();
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_size(input int unsigned value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[SIZE_W-1:0];
    @(posedge clk);
    cfg_we      <= 1'b0;
    size_shadow  = value[SIZE_W-1:0];
  endtask

  // Empty table: every search misses with index zero
  task automatic test_empty_table();
    idle_pct = 0;
    write_table_size(0);
    search_for(KEY_MIN);
    search_for(KEY_MAX);
    search_for(0);
  endtask

  // Small table with both extremes and a run of duplicates, then break order
  task automatic test_sorted_extremes();
    logic signed [KEY_W-1:0] vals [8];
    logic signed [KEY_W-1:0] keys [10];
    vals = '{KEY_MIN, -5, 0, 0, 0, 7, 100, KEY_MAX};
    keys = '{KEY_MIN, KEY_MAX, -5, 0, 100, 7, -6, 1, KEY_MAX - 1, KEY_MIN + 1};
    idle_pct = 0;
    for (int i = 0; i < 8; i++) load_entry(i, vals[i]);
    write_table_size(8);
    foreach (keys[i]) search_for(keys[i]);
    // Unsorted table: the probe order alone decides the answer
    load_entry(3, -32'sd100);
    search_for(-32'sd100);
    search_for(0);
    search_for(7);
  endtask

  // Whole table loaded, then full size and sizes past the depth
  task automatic test_full_table();
    idle_pct = 0;
    // Average step of about 2^22 spans the whole signed range over 1024 slots
    load_sorted(TABLE_DEPTH, ENTRY_MIN + longint'($urandom_range(0, 999)), 32'd8_388_607);
    write_table_size(TABLE_DEPTH);
    repeat (30) search_for(pick_key(TABLE_DEPTH));
    write_table_size(2047);
    repeat (15) search_for(pick_key(TABLE_DEPTH));
    write_table_size(TABLE_DEPTH + 1);
    repeat (5) search_for(pick_key(TABLE_DEPTH));
  endtask

  // Phases of sorted loads and searches, with stray loads mixed in
  task automatic test_random_phases();
    int unsigned       sent;
    int unsigned       span;
    int unsigned       searches;
    int unsigned       phase;
    longint unsigned   wide_step;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 85;
        default: idle_pct = 6;
      endcase
      span = ($urandom_range(7) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      write_table_size(span);
      case ($urandom_range(2))
        0: load_sorted(span, longint'($signed($urandom)), 3);
        1: load_sorted(span, longint'($signed($urandom)), 5000);
        default: begin
          wide_step = (64'd1 << 32) / span;
          if (wide_step > 64'hFFFF_FFFF) wide_step = 64'hFFFF_FFFF;
          load_sorted(span, ENTRY_MIN + longint'($urandom_range(0, 999)), wide_step[31:0]);
        end
      endcase
      searches = $urandom_range(10, 30);
      repeat (searches) begin
        if ($urandom_range(9) == 0) begin
          load_entry($urandom_range(TABLE_DEPTH - 1), $urandom);
        end else begin
          search_for(pick_key(span));
        end
      end
      sent  += span + searches;
      phase += 1;
    end
  endtask

  // Compare each result strobe with the oldest pending lookup
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: found=%b index=%0d", out_data.found,
                   out_data.match_index);
      end else begin
        want = pending_lookups.pop_front();
        if (out_data.found !== want.found || out_data.match_index !== want.match_index) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("lookup mismatch: expected found=%b index=%0d, got found=%b index=%0d",
                     want.found, want.match_index, out_data.found, out_data.match_index);
        end
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      watchdog_cycles = 0;
    end else begin
      watchdog_cycles++;
      if (watchdog_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_sorted_extremes();
    test_full_table();
    test_random_phases();
    settle();
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
